### hw/rtl/ppfa_pkg.sv
// ppfa_pkg: types, codes and reset constants of the physical page frame allocator
// used by physical_page_frame_allocator; no dependencies
package ppfa_pkg;

  localparam int unsigned NUM_PAGES_DEF = 4096;
  localparam int unsigned PAGE_SHIFT    = 12;

  localparam int unsigned FRAME_W = PAGE_SHIFT;
  localparam int unsigned LIMIT_W = 13;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned FIRST_PAGE_RST = 256;
  localparam int unsigned PAGE_LIMIT_RST = 4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_PAGE = 2'd0,
    CFG_PAGE_LIMIT = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_MEMORY    = 2'd1,
    ST_RANGE        = 2'd2,
    ST_UNREFERENCED = 2'd3
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC,
    S_FREE_CHK,
    S_RESP
  } state_e;

endpackage

### hw/rtl/physical_page_frame_allocator.sv
// physical_page_frame_allocator: first-fit page frame allocator with refcounts
// depends on ppfa_pkg
//
// usage: one request transaction on in_* (opcode allocate or free, frame_number),
// one result transaction on out_* (status, allocated_frame, pages_free) per request.
// configuration: cfg_we_i writes first_page (index 0) or page_limit (index 1)
// and reloads the free page count with the span size; write when idle.
// allocate: the scan reads one refcount entry per cycle from first_page up to the page
// limit and takes the first zero count; past the limit the result is out of memory.
// free: refcount read, then check and write back; a frame that is out of range goes
// straight to the result.
// reset: refcount entries 0 to min(NUM_PAGES, 8191)-1 are swept to zero, one entry per
// cycle, while in_ready_o stays low; config writes are taken.
// stall: a finished result waits in the output register; a following request is
// accepted meanwhile and holds its own result until the output register is free.
module physical_page_frame_allocator #(
  parameter int unsigned NUM_PAGES = ppfa_pkg::NUM_PAGES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ppfa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ppfa_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             opcode_i,
  input  logic [ppfa_pkg::FRAME_W-1:0]     frame_number_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       status_o,
  output logic [ppfa_pkg::FRAME_W-1:0]     allocated_frame_o,
  output logic [ppfa_pkg::LIMIT_W-1:0]     pages_free_o
);
  import ppfa_pkg::*;

  localparam int unsigned AW      = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int unsigned LIM_CAP = (NUM_PAGES < 8191) ? NUM_PAGES : 8191;
  localparam int unsigned CW      = (LIM_CAP > 1) ? $clog2(LIM_CAP) : 1;
  localparam int unsigned LIM_RST = (PAGE_LIMIT_RST > LIM_CAP) ? LIM_CAP : PAGE_LIMIT_RST;
  localparam int unsigned FREE_RST = (FIRST_PAGE_RST < LIM_RST) ?
                                     (LIM_RST - FIRST_PAGE_RST) : 0;

  function automatic logic [LIMIT_W-1:0] lim_f(input logic [LIMIT_W-1:0] pl);
    lim_f = (pl > LIMIT_W'(LIM_CAP)) ? LIMIT_W'(LIM_CAP) : pl;
  endfunction

  function automatic logic [LIMIT_W-1:0] span_f(input logic [FRAME_W-1:0] fp,
                                                input logic [LIMIT_W-1:0] pl);
    logic [LIMIT_W-1:0] l;
    l = lim_f(pl);
    span_f = ({1'b0, fp} < l) ? (l - {1'b0, fp}) : '0;
  endfunction

  state_e               state_q, state_d;
  logic [FRAME_W-1:0]   first_page_q, first_page_d;
  logic [LIMIT_W-1:0]   page_limit_q, page_limit_d;
  logic [LIMIT_W-1:0]   free_count_q, free_count_d;
  logic [CW-1:0]        clr_q, clr_d;
  logic [LIMIT_W-1:0]   scan_q, scan_d;
  logic [LIMIT_W-1:0]   chk_q, chk_d;
  logic                 pend_q, pend_d;
  logic [1:0]           res_status_q, res_status_d;
  logic [FRAME_W-1:0]   res_frame_q, res_frame_d;
  logic                 out_valid_q, out_valid_d;
  logic [1:0]           out_status_q, out_status_d;
  logic [FRAME_W-1:0]   out_frame_q, out_frame_d;
  logic [LIMIT_W-1:0]   out_free_q, out_free_d;

  logic [COUNT_W-1:0]   mem [NUM_PAGES];
  logic [COUNT_W-1:0]   rd_data_q;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [COUNT_W-1:0]   mem_wdata;
  logic [COUNT_W-1:0]   dec_cnt;

  logic [LIMIT_W-1:0]   lim_w, span_w;

  assign lim_w   = lim_f(page_limit_q);
  assign span_w  = span_f(first_page_q, page_limit_q);
  assign dec_cnt = rd_data_q - COUNT_W'(1);

  assign in_ready_o        = (state_q == S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign allocated_frame_o = out_frame_q;
  assign pages_free_o      = out_free_q;

  always_comb begin
    state_d      = state_q;
    first_page_d = first_page_q;
    page_limit_d = page_limit_q;
    free_count_d = free_count_q;
    clr_d        = clr_q;
    scan_d       = scan_q;
    chk_d        = chk_q;
    pend_d       = pend_q;
    res_status_d = res_status_q;
    res_frame_d  = res_frame_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_frame_d  = out_frame_q;
    out_free_d   = out_free_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = AW'(chk_q);
    mem_raddr    = AW'(scan_q);
    mem_wdata    = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(clr_q);
        mem_wdata = '0;
        clr_d     = clr_q + CW'(1);
        if (clr_q == CW'(LIM_CAP - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          res_status_d = ST_OK;
          res_frame_d  = '0;
          if (op_e'(opcode_i) == OP_ALLOC) begin
            scan_d  = {1'b0, first_page_q};
            pend_d  = 1'b0;
            state_d = S_ALLOC;
          end else if ((frame_number_i < first_page_q) ||
                       ({1'b0, frame_number_i} >= lim_w)) begin
            res_status_d = ST_RANGE;
            state_d      = S_RESP;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = AW'(frame_number_i);
            chk_d     = {1'b0, frame_number_i};
            state_d   = S_FREE_CHK;
          end
        end
      end
      S_ALLOC: begin
        if (pend_q && (rd_data_q == '0)) begin
          // first free frame found
          mem_we      = 1'b1;
          mem_waddr   = AW'(chk_q);
          mem_wdata   = COUNT_W'(1);
          res_frame_d = chk_q[FRAME_W-1:0];
          if (free_count_q != '0) begin
            free_count_d = free_count_q - LIMIT_W'(1);
          end
          state_d = S_RESP;
        end else if (scan_q < lim_w) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(scan_q);
          chk_d     = scan_q;
          pend_d    = 1'b1;
          scan_d    = scan_q + LIMIT_W'(1);
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          res_status_d = ST_NO_MEMORY;
          state_d      = S_RESP;
        end
      end
      S_FREE_CHK: begin
        if (rd_data_q == '0) begin
          res_status_d = ST_UNREFERENCED;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = AW'(chk_q);
          mem_wdata = dec_cnt;
          if ((dec_cnt == '0) && (free_count_q < span_w)) begin
            free_count_d = free_count_q + LIMIT_W'(1);
          end
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_frame_d  = res_frame_q;
          out_free_d   = free_count_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FIRST_PAGE: begin
          first_page_d = cfg_data_i[FRAME_W-1:0];
          free_count_d = span_f(cfg_data_i[FRAME_W-1:0], page_limit_q);
        end
        CFG_PAGE_LIMIT: begin
          page_limit_d = cfg_data_i[LIMIT_W-1:0];
          free_count_d = span_f(first_page_q, cfg_data_i[LIMIT_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      first_page_q <= FRAME_W'(FIRST_PAGE_RST);
      page_limit_q <= LIMIT_W'(PAGE_LIMIT_RST);
      free_count_q <= LIMIT_W'(FREE_RST);
      clr_q        <= '0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      first_page_q <= first_page_d;
      page_limit_q <= page_limit_d;
      free_count_q <= free_count_d;
      clr_q        <= clr_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q       <= scan_d;
    chk_q        <= chk_d;
    res_status_q <= res_status_d;
    res_frame_q  <= res_frame_d;
    out_status_q <= out_status_d;
    out_frame_q  <= out_frame_d;
    out_free_q   <= out_free_d;
  end

  // refcount memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  a_free_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_count_q <= span_w)
    else $error("free page count above span size");

  a_port_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("refcount read and write in the same cycle");

  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_RESP)
    else $error("result transaction raised outside the response state");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !in_ready_o && !out_valid_o)
    else $error("request taken during refcount clearing");

endmodule
